// File: rtl/pdsc_pkg.sv
// shared types, codes and reset constants for pps_disciplined_second_clock
`timescale 1ns / 1ps
`default_nettype none

package pdsc_pkg;

  localparam int MILLIS_PER_SECOND_DEF = 1000;
  localparam int MISS_LIMIT_DEF        = 2000;

  localparam logic [31:0] RELOAD_RESET = 32'd99999;
  localparam logic [15:0] GAIN_RESET   = 16'd50;
  localparam logic [31:0] START_RESET  = 32'd0;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SYNC      = 3'd1,
    OP_SET_UTC   = 3'd2,
    OP_READ      = 3'd3,
    OP_VALID_UP  = 3'd4,
    OP_VALID_DN  = 3'd5,
    OP_ARM_ALARM = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_SYNC  = 2'd1,
    ST_BAD_PARAM = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] seconds_value;
    logic [9:0]  millis_value;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] now_seconds;
    logic [9:0]  now_millis;
    logic        alarm_fired;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// File: rtl/pdsc_in_reg.sv
// input register stage for incoming requests
`timescale 1ns / 1ps
`default_nettype none

module pdsc_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire pdsc_pkg::item_t item_i,
  output logic                 valid_o,
  input  wire logic            adv_i,
  output pdsc_pkg::item_t      item_o
);

  logic            vld_q, vld_d;
  pdsc_pkg::item_t item_q;

  assign ready_o = !vld_q || adv_i;
  assign vld_d   = ready_o ? valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: rtl/pdsc_core.sv
// clock state, prescaler, sync trim, alarm and command decode
`timescale 1ns / 1ps
`default_nettype none

module pdsc_core #(
  parameter int MILLIS_PER_SECOND = pdsc_pkg::MILLIS_PER_SECOND_DEF,
  parameter int MISS_LIMIT        = pdsc_pkg::MISS_LIMIT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pdsc_pkg::cfg_wr_t cfg_i,
  input  wire logic              adv_i,
  input  wire pdsc_pkg::item_t   item_i,
  output pdsc_pkg::result_t      res_o
);

  localparam int CMAX = (MISS_LIMIT > 2 * MILLIS_PER_SECOND) ? MISS_LIMIT
                                                             : 2 * MILLIS_PER_SECOND;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int XW   = (CW > 11) ? CW : 11;
  localparam int MODW = $clog2(MILLIS_PER_SECOND);
  localparam int MXW  = (MODW > 10) ? MODW : 10;
  localparam int PW   = CW + 16;
  localparam int SW   = ((PW > 32) ? PW : 32) + 1;

  logic [31:0]   tick_q, tick_d;
  logic [31:0]   reload_q, reload_d;
  logic [CW-1:0] milli_q, milli_d;
  logic [MODW-1:0] mod_q, mod_d;
  logic [31:0]   sec_q, sec_d;
  logic          locked_q, locked_d;
  logic          valid_q, valid_d;
  logic [31:0]   al_sec_q, al_sec_d;
  logic [9:0]    al_ms_q, al_ms_d;
  logic          armed_q, armed_d;
  logic [15:0]   gain_q;

  logic [CW-1:0]   m_inc, milli_nx, err;
  logic [MODW-1:0] mod_nx;
  logic            hit, wrap, match, late, arm_bad, fired, bad;
  logic [31:0]     sec_step;
  logic [PW-1:0]   prod;
  logic [SW-1:0]   sum;
  logic [31:0]     grown, shrunk;
  logic [MXW-1:0]  mod_ext;

  // millisecond step and alarm match
  always_comb begin
    m_inc    = milli_q + 1'b1;
    hit      = (m_inc == CW'(MILLIS_PER_SECOND));
    wrap     = (m_inc >= CW'(MISS_LIMIT));
    milli_nx = wrap ? '0 : m_inc;
    mod_nx   = (wrap || mod_q == MODW'(MILLIS_PER_SECOND - 1)) ? '0 : mod_q + 1'b1;
    sec_step = sec_q + 32'(hit) + 32'(wrap);
    match    = armed_q && (sec_step == al_sec_q) &&
               ((XW'(milli_nx) == XW'(al_ms_q)) ||
                (XW'(milli_nx) == XW'(al_ms_q) + XW'(MILLIS_PER_SECOND)));
  end

  // phase error trim with saturation
  always_comb begin
    late   = (milli_q >= CW'(MILLIS_PER_SECOND));
    err    = late ? milli_q - CW'(MILLIS_PER_SECOND - 1)
                  : CW'(MILLIS_PER_SECOND - 1) - milli_q;
    prod   = PW'(err) * PW'(gain_q);
    sum    = SW'(reload_q) + SW'(prod);
    grown  = (sum > SW'({32{1'b1}})) ? '1 : sum[31:0];
    shrunk = (SW'(prod) >= SW'(reload_q)) ? '0 : reload_q - 32'(prod);
  end

  // arm in the past or out of range
  assign arm_bad = (32'(item_i.millis_value) >= 32'(MILLIS_PER_SECOND)) ||
                   (sec_q > item_i.seconds_value) ||
                   ((sec_q == item_i.seconds_value) &&
                    (MXW'(mod_q) >= MXW'(item_i.millis_value)));

  always_comb begin
    tick_d   = tick_q;
    reload_d = reload_q;
    milli_d  = milli_q;
    mod_d    = mod_q;
    sec_d    = sec_q;
    locked_d = locked_q;
    valid_d  = valid_q;
    al_sec_d = al_sec_q;
    al_ms_d  = al_ms_q;
    armed_d  = armed_q;
    fired    = 1'b0;
    bad      = 1'b0;
    case (item_i.op)
      pdsc_pkg::OP_TICK: begin
        if (tick_q >= reload_q) begin
          tick_d  = '0;
          milli_d = milli_nx;
          mod_d   = mod_nx;
          sec_d   = sec_step;
          if (wrap) begin
            locked_d = 1'b0;
          end
          if (match) begin
            fired   = 1'b1;
            armed_d = 1'b0;
          end
        end else begin
          tick_d = tick_q + 32'd1;
        end
      end
      pdsc_pkg::OP_SYNC: begin
        if (locked_q) begin
          if (late) begin
            reload_d = grown;
          end else begin
            reload_d = shrunk;
            sec_d    = sec_q + 32'd1;
          end
        end
        milli_d  = '0;
        mod_d    = '0;
        tick_d   = '0;
        locked_d = 1'b1;
      end
      pdsc_pkg::OP_SET_UTC: begin
        if (valid_q && (item_i.seconds_value != '1)) begin
          sec_d = item_i.seconds_value;
        end
      end
      pdsc_pkg::OP_READ: begin
      end
      pdsc_pkg::OP_VALID_UP: begin
        valid_d = 1'b1;
      end
      pdsc_pkg::OP_VALID_DN: begin
        valid_d = 1'b0;
      end
      pdsc_pkg::OP_ARM_ALARM: begin
        if (arm_bad) begin
          bad = 1'b1;
        end else begin
          al_sec_d = item_i.seconds_value;
          al_ms_d  = item_i.millis_value;
          armed_d  = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      reload_q <= pdsc_pkg::RELOAD_RESET;
      milli_q  <= '0;
      mod_q    <= '0;
      sec_q    <= pdsc_pkg::START_RESET;
      locked_q <= 1'b0;
      valid_q  <= 1'b0;
      al_sec_q <= '0;
      al_ms_q  <= '0;
      armed_q  <= 1'b0;
    end else if (adv_i) begin
      tick_q   <= tick_d;
      reload_q <= reload_d;
      milli_q  <= milli_d;
      mod_q    <= mod_d;
      sec_q    <= sec_d;
      locked_q <= locked_d;
      valid_q  <= valid_d;
      al_sec_q <= al_sec_d;
      al_ms_q  <= al_ms_d;
      armed_q  <= armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= pdsc_pkg::GAIN_RESET;
    end else if (cfg_i.en && (cfg_i.index == pdsc_pkg::CFG_GAIN)) begin
      gain_q <= cfg_i.data[15:0];
    end
  end

  assign mod_ext = MXW'(mod_d);

  always_comb begin
    if (bad) begin
      res_o.status = pdsc_pkg::ST_BAD_PARAM;
    end else if (valid_d && locked_d) begin
      res_o.status = pdsc_pkg::ST_OK;
    end else begin
      res_o.status = pdsc_pkg::ST_NOT_SYNC;
    end
    res_o.now_seconds = sec_d;
    res_o.now_millis  = mod_ext[9:0];
    res_o.alarm_fired = fired;
  end

endmodule

`default_nettype wire

// File: rtl/pdsc_out_reg.sv
// result register toward the output stream
`timescale 1ns / 1ps
`default_nettype none

module pdsc_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire pdsc_pkg::result_t res_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output pdsc_pkg::result_t      res_o
);

  logic              vld_q, vld_d;
  pdsc_pkg::result_t res_q;

  assign ready_o = !vld_q || ready_i;
  assign vld_d   = ready_o ? valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

// File: rtl/pps_disciplined_second_clock.sv
// top level of pps_disciplined_second_clock, a pps disciplined utc clock with one-shot alarm
// path: a request is held in the input register, then the result register loads when it moves
// into state, which can wait while the result slot is full and not draining
// throughput: one request per cycle while the result stream takes results, set by the single state update stage
// reset clears counters, lock, validity and alarm, loads the default reload, gain and start second
// the gain register applies at once; register writes to any other index are ignored
`timescale 1ns / 1ps
`default_nettype none

module pps_disciplined_second_clock #(
  parameter int MILLIS_PER_SECOND = pdsc_pkg::MILLIS_PER_SECOND_DEF,
  parameter int MISS_LIMIT        = pdsc_pkg::MISS_LIMIT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // seconds_value[31:0], millis_value[41:32]
  input  wire logic [2:0]  s_axis_tuser_i,   // opcode[2:0]
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // now_seconds[31:0], now_millis[41:32],
                                             // alarm_fired[42]
  output logic [1:0]       m_axis_tuser_o,   // status[1:0]
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  pdsc_pkg::item_t   s_item, core_item;
  pdsc_pkg::result_t core_res, out_res;
  pdsc_pkg::cfg_wr_t cfg_wr;
  logic              in_vld, out_rdy, adv;

  // unpack the request
  assign s_item.op            = pdsc_pkg::op_e'(s_axis_tuser_i);
  assign s_item.seconds_value = s_axis_tdata_i[31:0];
  assign s_item.millis_value  = s_axis_tdata_i[41:32];

  // register writes are always taken
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.en    = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // a request moves into state when the result slot is free or draining
  assign adv = in_vld && out_rdy;

  pdsc_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (s_item),
    .valid_o (in_vld),
    .adv_i   (adv),
    .item_o  (core_item)
  );

  pdsc_core #(
    .MILLIS_PER_SECOND (MILLIS_PER_SECOND),
    .MISS_LIMIT        (MISS_LIMIT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .adv_i  (adv),
    .item_i (core_item),
    .res_o  (core_res)
  );

  pdsc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld),
    .ready_o (out_rdy),
    .res_i   (core_res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  // pack the result, upper bits zero
  assign m_axis_tdata_o = {5'd0, out_res.alarm_fired, out_res.now_millis,
                           out_res.now_seconds};
  assign m_axis_tuser_o = out_res.status;

endmodule

`default_nettype wire
